// File: hw/rtl/pcpl_pkg.sv
// Shared types and constants of the palette code pixel lookup block.
package pcpl_pkg;

   // Default sizes
   localparam int PALETTE_DEPTH_DEF = 256;
   localparam int CODE_CHARS_DEF    = 4;

   // Item function codes
   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_LOAD   = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Reset value of the code width register
   localparam logic [2:0] CPP_RESET = 3'd1;

   // Stored colour of one palette entry
   typedef struct packed {
      logic        transparent;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } entry_color_type;

   // Token walking along the cell row (count travels beside it)
   typedef struct packed {
      logic            lookup;
      logic [31:0]     code;
      entry_color_type color;
      logic            found;
      entry_color_type hit_color;
   } cell_token_type;

   // Row-wide control to every cell
   typedef struct packed {
      logic        advance;
      logic [31:0] code_mask;
   } cell_ctrl_type;

endpackage

// File: hw/rtl/pcpl_if.sv
// Channel interfaces of the palette code pixel lookup block.
interface pcpl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] pixel_code;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;
   logic        is_clear;

   modport source (output valid, func, pixel_code, red_in, green_in, blue_in, is_clear,
                   input ready);
   modport sink   (input valid, func, pixel_code, red_in, green_in, blue_in, is_clear,
                   output ready);
endinterface

interface pcpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] argb;
   logic        matched;
   logic        empty_res;

   modport source (output valid, argb, matched, empty_res, input ready);
   modport sink   (input valid, argb, matched, empty_res, output ready);
endinterface

interface pcpl_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/pcpl_cell.sv
// One palette entry cell: stores a code and colour, checks the passing token.
module pcpl_cell #(
   parameter int CNT_W      = 9,
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pcpl_pkg::cell_ctrl_type ctrl,
   input  logic                    tok_valid_i,
   input  pcpl_pkg::cell_token_type tok_i,
   input  logic [CNT_W-1:0]        cnt_i,
   output logic                    tok_valid_o,
   output pcpl_pkg::cell_token_type tok_o,
   output logic [CNT_W-1:0]        cnt_o
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(CELL_INDEX);
   localparam bit               IS_FIRST = (CELL_INDEX == 0);

   logic [31:0]               entry_code_ff;
   pcpl_pkg::entry_color_type entry_color_ff;
   logic                      tok_valid_ff;
   pcpl_pkg::cell_token_type  tok_ff;
   logic [CNT_W-1:0]          cnt_ff;

   logic                      tok_valid_in;
   pcpl_pkg::cell_token_type  tok_in;
   logic                      active;
   logic                      code_hit;
   logic                      write_en;

   // Compare and update the token as it passes
   always_comb begin
      active   = (MY_INDEX < cnt_i);
      code_hit = (((entry_code_ff ^ tok_i.code) & ctrl.code_mask) == 32'd0);
      write_en = ctrl.advance && tok_valid_i && !tok_i.lookup && (cnt_i == MY_INDEX);
      tok_valid_in = tok_valid_i;
      tok_in       = tok_i;
      if (tok_i.lookup && active && !tok_i.found) begin
         if (code_hit) begin
            tok_in.found     = 1'b1;
            tok_in.hit_color = entry_color_ff;
         end else if (IS_FIRST) begin
            // entry 0 is the fallback on a miss
            tok_in.hit_color = entry_color_ff;
         end
      end
   end

   // Entry storage, written by a load token aimed at this cell
   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_code_ff  <= tok_i.code;
         entry_color_ff <= tok_i.color;
      end
   end

   // Token stage towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         tok_ff <= tok_in;
         cnt_ff <= cnt_i;
      end
   end

   assign tok_valid_o = tok_valid_ff;
   assign tok_o       = tok_ff;
   assign cnt_o       = cnt_ff;

endmodule

// File: hw/rtl/palette_code_pixel_lookup.sv
// Top level of the palette code pixel lookup block: control and cell row.
//
//  channel | interface     | moves
//  --------+---------------+------------------------------------------------
//  req     | pcpl_req_if   | clear / load / look-up items in
//  rsp     | pcpl_rsp_if   | look-up results out (argb, matched, empty_res)
//  csr     | pcpl_csr_if   | chars_per_pixel write, always ready
//
// A clear is taken without sending a token. A load or look-up sends a token down the
// row of PALETTE_DEPTH cells, one cell a cycle unless a stalled result holds the row;
// the next transaction is accepted only after the token has left the last cell.
// A load to a full palette is accepted and dropped. Reset (synchronous) empties the
// palette at once; entry contents are not cleared. A stalled result holds the row.
module palette_code_pixel_lookup #(
   parameter int PALETTE_DEPTH = pcpl_pkg::PALETTE_DEPTH_DEF,
   parameter int CODE_CHARS    = pcpl_pkg::CODE_CHARS_DEF
) (
   input logic          clock,
   input logic          reset,
   pcpl_req_if.sink     req,
   pcpl_rsp_if.source   rsp,
   pcpl_csr_if.sink     csr
);

   localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
   localparam int CODE_LIMIT = (CODE_CHARS < 4) ? CODE_CHARS : 4;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(PALETTE_DEPTH);
   localparam logic [2:0]       CPP_LIMIT  = 3'(CODE_LIMIT);

   logic [2:0]        cpp_ff;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              any_trans_ff, any_trans_in;
   logic              busy_ff,   busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       argb_ff,   argb_in;
   logic              matched_ff, matched_in;
   logic              empty_ff,  empty_in;

   logic                      accept;
   logic                      issue;
   logic                      tail_exit;
   logic [2:0]                eff_chars;
   pcpl_pkg::cell_ctrl_type   ctrl;
   pcpl_pkg::cell_token_type  head_tok;
   pcpl_pkg::entry_color_type tail_color;

   logic                      chain_vld [0:PALETTE_DEPTH];
   pcpl_pkg::cell_token_type  chain_tok [0:PALETTE_DEPTH];
   logic [CNT_W-1:0]          chain_cnt [0:PALETTE_DEPTH];
   logic [PALETTE_DEPTH:0]    vld_vec;

   // Configuration register
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cpp_ff <= pcpl_pkg::CPP_RESET;
      end else if (csr.valid) begin
         cpp_ff <= csr.data;
      end
   end

   // Code byte mask from the clamped code width
   always_comb begin
      eff_chars = cpp_ff;
      if (cpp_ff == 3'd0) begin
         eff_chars = 3'd1;
      end
      if (eff_chars > CPP_LIMIT) begin
         eff_chars = CPP_LIMIT;
      end
      for (int k = 0; k < 4; k++) begin
         ctrl.code_mask[k*8 +: 8] = (3'(k) < eff_chars) ? 8'hFF : 8'h00;
      end
      ctrl.advance = !(chain_vld[PALETTE_DEPTH] && chain_tok[PALETTE_DEPTH].lookup &&
                       rsp_valid_ff && !rsp.ready);
   end

   // Request side: one transaction in the row at a time
   assign req.ready = !busy_ff;
   assign accept    = req.valid && req.ready;
   assign tail_exit = chain_vld[PALETTE_DEPTH] && ctrl.advance;

   always_comb begin
      issue = 1'b0;
      if (accept) begin
         if (req.func == pcpl_pkg::FUNC_LOOKUP) begin
            issue = 1'b1;
         end else if ((req.func == pcpl_pkg::FUNC_LOAD) && (count_ff != FULL_COUNT)) begin
            issue = 1'b1;
         end
      end
   end

   // Token entering cell 0
   always_comb begin
      head_tok.lookup    = (req.func == pcpl_pkg::FUNC_LOOKUP);
      head_tok.code      = req.pixel_code;
      head_tok.found     = 1'b0;
      head_tok.hit_color = '0;
      if (req.is_clear) begin
         head_tok.color             = '0;
         head_tok.color.transparent = 1'b1;
      end else begin
         head_tok.color.transparent = 1'b0;
         head_tok.color.red         = req.red_in;
         head_tok.color.green       = req.green_in;
         head_tok.color.blue        = req.blue_in;
      end
   end

   assign chain_vld[0] = issue;
   assign chain_tok[0] = head_tok;
   assign chain_cnt[0] = count_ff;

   // Row of palette cells
   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      pcpl_cell #(
         .CNT_W      (CNT_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .tok_valid_i (chain_vld[i]),
         .tok_i       (chain_tok[i]),
         .cnt_i       (chain_cnt[i]),
         .tok_valid_o (chain_vld[i+1]),
         .tok_o       (chain_tok[i+1]),
         .cnt_o       (chain_cnt[i+1])
      );
   end

   // Palette fill count and busy flag
   always_comb begin
      count_in     = count_ff;
      any_trans_in = any_trans_ff;
      busy_in      = busy_ff;
      if (accept && (req.func == pcpl_pkg::FUNC_CLEAR)) begin
         count_in     = '0;
         any_trans_in = 1'b0;
      end
      if (issue && (req.func == pcpl_pkg::FUNC_LOAD)) begin
         count_in     = count_ff + CNT_W'(1);
         any_trans_in = any_trans_ff | req.is_clear;
      end
      if (issue) begin
         busy_in = 1'b1;
      end else if (tail_exit) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         any_trans_ff <= 1'b0;
         busy_ff      <= 1'b0;
      end else begin
         count_ff     <= count_in;
         any_trans_ff <= any_trans_in;
         busy_ff      <= busy_in;
      end
   end

   // Result register
   assign tail_color = chain_tok[PALETTE_DEPTH].hit_color;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      argb_in      = argb_ff;
      matched_in   = matched_ff;
      empty_in     = empty_ff;
      if (tail_exit && chain_tok[PALETTE_DEPTH].lookup) begin
         rsp_valid_in = 1'b1;
         if (chain_cnt[PALETTE_DEPTH] == '0) begin
            argb_in    = 32'd0;
            matched_in = 1'b0;
            empty_in   = 1'b1;
         end else begin
            argb_in[31:24] = (any_trans_ff && tail_color.transparent) ? 8'h00
                                                                     : pcpl_pkg::ALPHA_OPAQUE;
            argb_in[23:16] = tail_color.red[15:8];
            argb_in[15:8]  = tail_color.green[15:8];
            argb_in[7:0]   = tail_color.blue[15:8];
            matched_in     = chain_tok[PALETTE_DEPTH].found;
            empty_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      argb_ff    <= argb_in;
      matched_ff <= matched_in;
      empty_ff   <= empty_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.argb      = argb_ff;
   assign rsp.matched   = matched_ff;
   assign rsp.empty_res = empty_ff;

   // Token valid bits gathered for checking
   always_comb begin
      for (int j = 0; j <= PALETTE_DEPTH; j++) begin
         vld_vec[j] = chain_vld[j];
      end
   end

`ifndef SYNTHESIS
   // At most one token anywhere in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(vld_vec) <= 1)
      else $error("more than one token in the cell row");

   // An idle block has no token in the cell row
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (vld_vec[PALETTE_DEPTH:1] == '0))
      else $error("token in the row while idle");

   // The fill count never passes the palette depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("palette count beyond depth");
`endif

endmodule
